FILE: src/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared constants, action codes and the job record for the MSB-first packer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbp_pkg;

    localparam int WORD_BITS_DEF  = 32;
    localparam int MAX_FIELD_BITS = 32;
    localparam int MAX_BYTES      = 8;
    localparam int JOB_W          = 64;
    localparam int JOB_BYTES_W    = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int COUNT_W        = 6;

    typedef enum logic [1:0] {
        ACT_BITS  = 2'd0,
        ACT_BYTES = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NOP   = 2'd3
    } mbp_act_t;

    // data is left aligned, bytes leave from the top
    typedef struct packed {
        logic [JOB_W-1:0]       data;
        logic [JOB_BYTES_W-1:0] nbytes;
        logic                   last;
    } mbp_job_t;

endpackage

`default_nettype wire

FILE: src/msb_first_bit_packer_core.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core
// Packs variable-width fields MSB first into a word and streams big-endian bytes.
// ----------------------------------------------------------------------------
// The front takes the next item at the clock edge of the current item's last
// front step and works on it from the following cycle; a bit write makes one
// word job each time it fills the pack word and merges any bits left over,
// a byte write with bits pending first sends those bits as a job and then its
// own bytes, if it has any, a flush sends the pending bits, and every front
// step that makes a job waits while the queue is full. Jobs go through a
// four-entry queue to the back, which sends one byte per cycle while m_tready
// is high, so the sustained rate is set by the output. No clearing pass after
// reset.
`default_nettype none

module msb_first_bit_packer_core
    import mbp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // value [63:0], count [69:64]
    input  wire logic [1:0]  s_tuser,   // action [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte [7:0]
    output logic             m_tlast
);

    mbp_job_t front_job, back_job;
    logic     job_push, queue_full, job_pop, queue_valid;

    mbp_front #(
        .WORD_BITS(WORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_action  (mbp_act_t'(s_tuser)),
        .s_value   (s_tdata[63:0]),
        .s_count   (s_tdata[69:64]),
        .job       (front_job),
        .job_push  (job_push),
        .queue_full(queue_full)
    );

    mbp_fifo #(
        .WIDTH($bits(mbp_job_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_data(front_job),
        .full     (queue_full),
        .pop      (job_pop),
        .pop_data (back_job),
        .not_empty(queue_valid)
    );

    mbp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_valid(queue_valid),
        .job      (back_job),
        .job_pop  (job_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> !queue_full)
        else $error("job pushed into a full queue");

    a_job_size: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> (front_job.nbytes != '0) && (front_job.nbytes <= JOB_BYTES_W'(MAX_BYTES)))
        else $error("job byte count out of range");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> queue_valid)
        else $error("job taken from an empty queue");

endmodule

`default_nettype wire

FILE: src/mbp_fifo.sv
// ----------------------------------------------------------------------------
// mbp_fifo
// Small register queue that decouples the packing front from the byte back.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/mbp_front.sv
// ----------------------------------------------------------------------------
// mbp_front
// Accepts items, keeps the pack word and turns items into byte jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_front
    import mbp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire mbp_act_t           s_action,
    input  wire logic [63:0]        s_value,
    input  wire logic [COUNT_W-1:0] s_count,
    output mbp_job_t                job,
    output logic                    job_push,
    input  wire logic               queue_full
);

    localparam int FREE_W     = $clog2(WORD_BITS + 1);
    localparam int CMP_W      = (FREE_W > COUNT_W) ? FREE_W : COUNT_W;
    localparam int INS_W      = WORD_BITS + MAX_FIELD_BITS;
    localparam int UX_W       = FREE_W + 1;
    localparam int WORD_BYTES = (WORD_BITS + 7) / 8;

    logic                 work_valid_reg;
    mbp_act_t             act_reg;
    logic                 phase_reg, phase_next;
    logic [63:0]          val_reg, val_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [FREE_W-1:0]    free_reg, free_next;

    logic [FREE_W-1:0]    used;
    logic [UX_W-1:0]      used_rnd;
    logic [INS_W-1:0]     ins;
    logic [WORD_BITS-1:0] word_ins;
    logic [COUNT_W-1:0]   take, rem_next;
    logic                 filled, word_empty;
    logic [3:0]           val_shift;
    logic                 push, done, step;
    logic [COUNT_W-1:0]   cap_bits, cap_bytes;

    assign used       = FREE_W'(WORD_BITS) - free_reg;
    assign used_rnd   = UX_W'(used) + UX_W'(7);
    assign word_empty = (free_reg == FREE_W'(WORD_BITS));
    assign ins        = {val_reg[63:32], {WORD_BITS{1'b0}}} >> used;
    assign word_ins   = word_reg | ins[INS_W-1 -: WORD_BITS];
    assign filled     = (CMP_W'(cnt_reg) >= CMP_W'(free_reg));
    assign take       = filled ? COUNT_W'(free_reg) : cnt_reg;
    assign rem_next   = cnt_reg - take;
    assign val_shift  = 4'(MAX_BYTES) - cnt_reg[3:0];

    always_comb begin
        push       = 1'b0;
        done       = 1'b0;
        job        = '0;
        word_next  = word_reg;
        free_next  = free_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        unique case (act_reg)
            ACT_BITS: begin
                push        = filled;
                job.data    = JOB_W'(word_ins) << (JOB_W - WORD_BITS);
                job.nbytes  = JOB_BYTES_W'(WORD_BYTES);
                job.last    = (CMP_W'(rem_next) < CMP_W'(WORD_BITS));
                word_next   = filled ? '0 : word_ins;
                free_next   = filled ? FREE_W'(WORD_BITS) : free_reg - FREE_W'(take);
                val_next    = val_reg << take;
                cnt_next    = rem_next;
                done        = (rem_next == '0);
            end
            ACT_BYTES: begin
                if (!phase_reg && !word_empty) begin
                    push       = 1'b1;
                    job.data   = JOB_W'(word_reg) << (JOB_W - WORD_BITS);
                    job.nbytes = JOB_BYTES_W'(used_rnd >> 3);
                    job.last   = (cnt_reg == '0);
                    word_next  = '0;
                    free_next  = FREE_W'(WORD_BITS);
                    phase_next = 1'b1;
                    done       = (cnt_reg == '0);
                end else begin
                    push       = (cnt_reg != '0);
                    job.data   = val_reg << {val_shift[2:0], 3'b000};
                    job.nbytes = cnt_reg[JOB_BYTES_W-1:0];
                    job.last   = 1'b1;
                    done       = 1'b1;
                end
            end
            ACT_FLUSH: begin
                push       = !word_empty;
                job.data   = JOB_W'(word_reg) << (JOB_W - WORD_BITS);
                job.nbytes = JOB_BYTES_W'(used_rnd >> 3);
                job.last   = 1'b1;
                word_next  = '0;
                free_next  = FREE_W'(WORD_BITS);
                done       = 1'b1;
            end
            ACT_NOP: begin
                done = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    assign step     = work_valid_reg && (!push || !queue_full);
    assign job_push = work_valid_reg && push && !queue_full;
    assign s_ready  = !work_valid_reg || (step && done);

    assign cap_bits  = (s_count > COUNT_W'(MAX_FIELD_BITS)) ? COUNT_W'(MAX_FIELD_BITS) : s_count;
    assign cap_bytes = (s_count > COUNT_W'(MAX_BYTES)) ? COUNT_W'(MAX_BYTES) : s_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            word_reg       <= '0;
            free_reg       <= FREE_W'(WORD_BITS);
        end else begin
            if (step) begin
                word_reg <= word_next;
                free_reg <= free_next;
            end
            if (s_valid && s_ready) begin
                work_valid_reg <= 1'b1;
            end else if (step && done) begin
                work_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg   <= s_action;
            phase_reg <= 1'b0;
            if (s_action == ACT_BITS) begin
                val_reg <= {s_value[31:0] << (COUNT_W'(MAX_FIELD_BITS) - cap_bits), 32'd0};
                cnt_reg <= cap_bits;
            end else begin
                val_reg <= s_value;
                cnt_reg <= cap_bytes;
            end
        end else if (step) begin
            val_reg   <= val_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/mbp_back.sv
// ----------------------------------------------------------------------------
// mbp_back
// Takes queued byte jobs and sends one byte per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_back
    import mbp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     job_valid,
    input  wire mbp_job_t job,
    output logic          job_pop,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast
);

    logic [JOB_W-1:0]       sh_reg;
    logic [JOB_BYTES_W-1:0] cnt_reg;
    logic                   last_reg;
    logic                   load, sent;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = sh_reg[JOB_W-1 -: 8];
    assign m_tlast  = last_reg && (cnt_reg == JOB_BYTES_W'(1));
    assign sent     = m_tvalid && m_tready;
    assign load     = (cnt_reg == '0) || (sent && cnt_reg == JOB_BYTES_W'(1));
    assign job_pop  = load && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= job_valid ? job.nbytes : '0;
        end else if (sent) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            sh_reg   <= job.data;
            last_reg <= job.last;
        end else if (sent) begin
            sh_reg <= sh_reg << 8;
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_msb_first_bit_packer_core.sv
// ----------------------------------------------------------------------------
// tb_msb_first_bit_packer_core
// Self-checking bench for the MSB-first bit packer: random and directed bit,
// byte, flush and no-op words go in with random gaps; every streamed byte and
// its tlast flag is compared against a behavioral model of the packing word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_msb_first_bit_packer_core
    import mbp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        mbp_act_t    act;
        logic [63:0] value;
        logic [5:0]  count;
        int          gap;
        bit          drain;
    } pk_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } pk_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;  // value [63:0], count [69:64]
    logic [1:0]  s_tuser  = '0;  // action [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // out_byte [7:0]
    logic        m_tlast;

    pk_item_t pend_q[$];
    pk_byte_t byte_q[$];
    pk_item_t cur;

    logic [31:0] pk_word = '0;
    int          pk_free = 32;

    int   n_items   = 0;
    int   n_in      = 0;
    int   n_err     = 0;
    int   tx_idle   = 0;
    int   rx_stall  = 0;
    int   rx_stall_n;
    logic rx_hold   = 1'b0;

    msb_first_bit_packer_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic push_byte(input logic [7:0] b);
        pk_byte_t e;
        e.data = b;
        e.last = 1'b0;
        byte_q.push_back(e);
    endtask

    // send the leading bytes that hold bits, then start an empty word
    task automatic emit_word();
        int nb;
        nb = (32 - pk_free + 7) / 8;
        for (int k = 0; k < nb; k++)
            push_byte(pk_word[31 - 8*k -: 8]);
        pk_word = '0;
        pk_free = 32;
    endtask

    task automatic pack_item(input mbp_act_t act, input logic [63:0] val,
                             input logic [5:0] cnt);
        int n0;
        int nb;
        n0 = byte_q.size();
        case (act)
            ACT_BITS: begin
                nb = (cnt > 32) ? 32 : int'(cnt);
                for (int k = nb - 1; k >= 0; k--) begin
                    pk_free--;
                    pk_word[pk_free] = val[k];
                    if (pk_free == 0)
                        emit_word();
                end
            end
            ACT_BYTES: begin
                if (pk_free < 32)
                    emit_word();
                nb = (cnt > 8) ? 8 : int'(cnt);
                for (int k = nb - 1; k >= 0; k--)
                    push_byte(val[8*k +: 8]);
            end
            ACT_FLUSH: begin
                if (pk_free < 32)
                    emit_word();
            end
            default: ;
        endcase
        if (byte_q.size() > n0)
            byte_q[$].last = 1'b1;
    endtask

    task automatic add_item(input mbp_act_t act, input logic [63:0] val,
                            input logic [5:0] cnt, input bit drain);
        pk_item_t it;
        it.act   = act;
        it.value = val;
        it.count = cnt;
        // burst section keeps the input busy while the output is held off
        it.gap   = (n_items >= 40 && n_items < 95) ? 0 : $urandom_range(0, 6);
        it.drain = drain;
        pend_q.push_back(it);
        n_items++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_idle  <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                pack_item(cur.act, cur.value, cur.count);
                n_in <= n_in + 1;
            end
            if (pend_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (tx_idle < pend_q[0].gap) begin
                tx_idle  <= tx_idle + 1;
                s_tvalid <= 1'b0;
            end else if (pend_q[0].drain && byte_q.size() != 0) begin
                s_tvalid <= 1'b0;
            end else begin
                cur = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, cur.count, cur.value};
                s_tuser  <= cur.act;
                tx_idle  <= 0;
            end
        end
    end

    // output monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (byte_q.size() == 0) begin
                    $display("%0t: unexpected word data %02h last %0b",
                             $time, m_tdata, m_tlast);
                    n_err++;
                end else begin
                    if (m_tdata !== byte_q[0].data) begin
                        $display("%0t: data mismatch expected %02h actual %02h",
                                 $time, byte_q[0].data, m_tdata);
                        n_err++;
                    end
                    if (m_tlast !== byte_q[0].last) begin
                        $display("%0t: last mismatch expected %0b actual %0b",
                                 $time, byte_q[0].last, m_tlast);
                        n_err++;
                    end
                    void'(byte_q.pop_front());
                end
                rx_stall_n = (n_in >= 110 && n_in < 140) ? 0 : $urandom_range(0, 6);
            end else begin
                rx_stall_n = (rx_stall > 0) ? rx_stall - 1 : 0;
            end
            rx_stall <= rx_stall_n;
            m_tready <= (rx_stall_n == 0) && !rx_hold;
        end
    end

    // long output hold-off while the input keeps offering words
    initial begin
        while (n_in < 45)
            @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin
        #3ms;
        $display("msb_first_bit_packer_core test failed");
        $finish;
    end

    initial begin
        int r;
        int c;
        logic [5:0] bcnt;

        // directed part
        add_item(ACT_BITS,  64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  1'b0);
        add_item(ACT_FLUSH, 64'h0,                   6'd0,  1'b0);
        add_item(ACT_BITS,  64'hFFFF_FFFF_FFFF_FFFF, 6'd32, 1'b0);
        add_item(ACT_BITS,  64'h0,                   6'd32, 1'b0);
        add_item(ACT_BITS,  64'h1,                   6'd1,  1'b0);
        add_item(ACT_BITS,  64'h55,                  6'd7,  1'b0);
        add_item(ACT_FLUSH, 64'h0,                   6'd0,  1'b0);
        add_item(ACT_BITS,  64'h5,                   6'd3,  1'b0);
        add_item(ACT_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b0);
        add_item(ACT_BITS,  64'hA5A5_A5A5_5A5A_5A5A, 6'd63, 1'b0);
        add_item(ACT_BITS,  64'h000F_EDCB,           6'd20, 1'b0);
        add_item(ACT_BITS,  64'h0001_2345,           6'd20, 1'b0);
        add_item(ACT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0,  1'b0);
        add_item(ACT_BYTES, 64'h1234_5678_9ABC_DEF0, 6'd0,  1'b0);
        add_item(ACT_BYTES, 64'h0123_4567_89AB_CDEF, 6'd1,  1'b0);
        add_item(ACT_BITS,  64'h3,                   6'd2,  1'b0);
        add_item(ACT_BYTES, 64'h0123_4567_89AB_CDEF, 6'd2,  1'b0);
        add_item(ACT_BYTES, 64'h0123_4567_89AB_CDEF, 6'd3,  1'b0);
        add_item(ACT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 6'd4,  1'b0);
        add_item(ACT_BITS,  64'h7F,                  6'd9,  1'b0);
        add_item(ACT_BYTES, 64'hFEDC_BA98_7654_3210, 6'd5,  1'b0);
        add_item(ACT_BYTES, 64'hFEDC_BA98_7654_3210, 6'd6,  1'b0);
        add_item(ACT_BYTES, 64'hFEDC_BA98_7654_3210, 6'd7,  1'b0);
        add_item(ACT_BITS,  64'h2AB,                 6'd11, 1'b0);
        add_item(ACT_NOP,   64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b0);
        add_item(ACT_BYTES, 64'hFFFF_FFFF_0000_0000, 6'd8,  1'b0);
        add_item(ACT_BYTES, 64'h8000_0000_0000_0001, 6'd63, 1'b1);

        // random part
        for (int i = 0; i < 132; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                c = $urandom_range(0, 99);
                if (c < 85)
                    bcnt = 6'($urandom_range(1, 32));
                else if (c < 93)
                    bcnt = 6'd0;
                else
                    bcnt = 6'($urandom_range(33, 63));
                add_item(ACT_BITS, rand64(), bcnt,
                         (n_items >= 95) && ($urandom_range(0, 24) == 0));
            end else if (r < 80) begin
                if ($urandom_range(0, 9) < 7)
                    bcnt = 6'(1 << $urandom_range(0, 3));
                else
                    bcnt = 6'($urandom_range(0, 63));
                add_item(ACT_BYTES, rand64(), bcnt, 1'b0);
            end else if (r < 93) begin
                add_item(ACT_FLUSH, rand64(), 6'($urandom_range(0, 63)), 1'b0);
            end else begin
                add_item(ACT_NOP, rand64(), 6'($urandom_range(0, 63)), 1'b0);
            end
        end
        add_item(ACT_FLUSH, 64'h0, 6'd0, 1'b0);

        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(posedge aclk);
        while (pend_q.size() != 0 || s_tvalid || byte_q.size() != 0);
        repeat (50) @(posedge aclk);

        if (byte_q.size() != 0) begin
            $display("%0t: %0d expected words never arrived, next %02h last %0b",
                     $time, byte_q.size(), byte_q[0].data, byte_q[0].last);
            n_err++;
        end
        if (n_err == 0)
            $display("msb_first_bit_packer_core test passed");
        else
            $display("msb_first_bit_packer_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
